// ----- hw/rtl/m68k_pkg.sv -----
// Shared types and constants for the 68000 subset interpreter.
package m68k_pkg;

    localparam int MEM_BYTES = 4096;
    localparam int MEM_AW = $clog2(MEM_BYTES);
    localparam int SIZE_W = 13;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] ACT_WR_MEM = 3'd0;
    localparam logic [2:0] ACT_RD_MEM = 3'd1;
    localparam logic [2:0] ACT_WR_REG = 3'd2;
    localparam logic [2:0] ACT_RD_REG = 3'd3;
    localparam logic [2:0] ACT_RUN = 3'd4;

    localparam logic [2:0] ST_DONE = 3'd0;
    localparam logic [2:0] ST_LIMIT = 3'd1;
    localparam logic [2:0] ST_RTS = 3'd2;
    localparam logic [2:0] ST_RANGE = 3'd3;
    localparam logic [2:0] ST_ILLEGAL = 3'd4;

    localparam logic [4:0] SEL_PC = 5'd16;
    localparam logic [4:0] SEL_SR = 5'd17;

    localparam logic [15:0] MASK_MOVEQ = 16'hf100;
    localparam logic [15:0] CODE_MOVEQ = 16'h7000;
    localparam logic [15:0] MASK_QUICK = 16'hf0c0;
    localparam logic [15:0] CODE_QUICK = 16'h5080;
    localparam logic [15:0] MASK_STORE = 16'hfff8;
    localparam logic [15:0] CODE_STORE = 16'h23c0;
    localparam logic [15:0] MASK_LOAD = 16'hf1ff;
    localparam logic [15:0] CODE_LOAD = 16'h2039;
    localparam logic [15:0] CODE_RTS = 16'h4e75;

    typedef enum logic [2:0] {
        KIND_MEM_WR = 3'd0,
        KIND_MEM_RD = 3'd1,
        KIND_REG_WR = 3'd2,
        KIND_REG_RD = 3'd3,
        KIND_RUN = 3'd4,
        KIND_NONE = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t kind;
        logic mem_ok;
        logic [MEM_AW-1:0] mem_address;
        logic [7:0] mem_byte;
        logic [4:0] reg_select;
        logic [31:0] reg_value;
        logic [31:0] step_limit;
    } cmd_t;

    typedef struct packed {
        logic [2:0] status;
        logic [31:0] fault_address;
        logic [15:0] fault_opcode;
        logic [31:0] executed_count;
        logic [31:0] read_value;
    } res_t;

endpackage

// ----- hw/rtl/m68k_front.sv -----
// Front end: accept and classify requests into a short command queue.
module m68k_front (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [2:0] action,
    input  logic [11:0] mem_address,
    input  logic [7:0] mem_byte,
    input  logic [4:0] reg_select,
    input  logic [31:0] reg_value,
    input  logic [31:0] step_limit,
    output logic cmd_valid,
    input  logic cmd_ready,
    output m68k_pkg::cmd_t cmd
);
    import m68k_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    cmd_t q_reg [QUEUE_DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0] cnt_reg;
    cmd_t c;
    logic push, pop;

    always_comb
    begin
        c = '0;
        unique case (action)
            ACT_WR_MEM: c.kind = KIND_MEM_WR;
            ACT_RD_MEM: c.kind = KIND_MEM_RD;
            ACT_WR_REG: c.kind = KIND_REG_WR;
            ACT_RD_REG: c.kind = KIND_REG_RD;
            ACT_RUN: c.kind = KIND_RUN;
            default: c.kind = KIND_NONE;
        endcase
        c.mem_ok = ({20'd0, mem_address} < 32'(MEM_BYTES));
        c.mem_address = MEM_AW'(mem_address);
        c.mem_byte = mem_byte;
        c.reg_select = reg_select;
        c.reg_value = reg_value;
        c.step_limit = step_limit;
    end

    assign in_ready = (cnt_reg != (PW+1)'(QUEUE_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd = q_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop = cmd_valid && cmd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end
endmodule

// ----- hw/rtl/m68k_back.sv -----
// Back end: register file, byte memory, instruction sequencer and result register.
module m68k_back (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  m68k_pkg::cmd_t cmd,
    input  logic [12:0] mem_size,
    output logic res_valid,
    input  logic res_ready,
    output m68k_pkg::res_t res
);
    import m68k_pkg::*;

    localparam int CW = $clog2(MEM_BYTES + 1);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_CLEAR  = 12'b000000000010,
        S_MEMRD  = 12'b000000000100,
        S_CHECK  = 12'b000000001000,
        S_FETCH  = 12'b000000010000,
        S_EXEC   = 12'b000000100000,
        S_EXTRD  = 12'b000001000000,
        S_EXTCHK = 12'b000010000000,
        S_DATA   = 12'b000100000000,
        S_WRITE  = 12'b001000000000,
        S_FINISH = 12'b010000000000,
        S_OUT    = 12'b100000000000
    } state_t;

    state_t state_reg;
    logic [7:0] mem [MEM_BYTES];
    logic [7:0] mrd_reg;
    logic [CW-1:0] clr_reg;
    logic [31:0] dreg [8];
    logic [31:0] areg [8];
    logic [31:0] pc_reg;
    logic [15:0] sr_reg;
    cmd_t cur_reg;
    res_t res_reg;
    logic [31:0] cnt_reg, ipc_reg, ptr_reg, addr_reg, word_reg;
    logic [15:0] op_reg;
    logic [1:0] bi_reg;
    logic [2:0] mode_reg;

    localparam logic [2:0] M_FETCH = 3'd0;
    localparam logic [2:0] M_EXT = 3'd1;
    localparam logic [2:0] M_LOAD = 3'd2;
    localparam logic [2:0] M_POP = 3'd3;
    localparam logic [2:0] M_STORE = 3'd4;

    logic [12:0] size;
    logic [31:0] need;
    logic in_rng;
    logic [MEM_AW-1:0] rd_addr;
    logic [31:0] sext, qv, dst, sum, dif;

    assign size = (mem_size > 13'(MEM_BYTES)) ? 13'(MEM_BYTES) : mem_size;
    assign need = (mode_reg == M_FETCH) ? 32'd2 : 32'd4;
    assign in_rng = (ptr_reg <= {19'd0, size}) && ({19'd0, size} - ptr_reg >= need);
    assign rd_addr = (state_reg == S_IDLE) ? cur_reg.mem_address
        : MEM_AW'(ptr_reg + {30'd0, bi_reg});

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign res = res_reg;

    assign sext = {{24{op_reg[7]}}, op_reg[7:0]};
    assign qv = (op_reg[11:9] == 3'd0) ? 32'd8 : {29'd0, op_reg[11:9]};
    assign dst = dreg[op_reg[2:0]];
    assign sum = dst + qv;
    assign dif = dst - qv;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            mem[MEM_AW'(clr_reg)] <= 8'd0;
        end
        else if (state_reg == S_IDLE && cmd_valid && cmd.kind == KIND_MEM_WR && cmd.mem_ok)
        begin
            mem[cmd.mem_address] <= cmd.mem_byte;
        end
        else if (state_reg == S_WRITE)
        begin
            mem[MEM_AW'(ptr_reg + {30'd0, bi_reg})] <= word_reg[31:24];
        end
        mrd_reg <= mem[(state_reg == S_IDLE) ? cmd.mem_address : rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            pc_reg <= '0;
            sr_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                dreg[i] <= '0;
                areg[i] <= '0;
            end
            cur_reg <= '0;
            res_reg <= '0;
            cnt_reg <= '0;
            ipc_reg <= '0;
            ptr_reg <= '0;
            addr_reg <= '0;
            word_reg <= '0;
            op_reg <= '0;
            bi_reg <= '0;
            mode_reg <= M_FETCH;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == CW'(MEM_BYTES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cur_reg <= cmd;
                        res_reg <= '0;
                        cnt_reg <= '0;
                        unique case (cmd.kind)
                            KIND_MEM_RD: state_reg <= S_MEMRD;
                            KIND_RUN:
                            begin
                                mode_reg <= M_FETCH;
                                ptr_reg <= pc_reg;
                                ipc_reg <= pc_reg;
                                state_reg <= S_CHECK;
                            end
                            KIND_REG_WR:
                            begin
                                if (cmd.reg_select < 5'd8)
                                    dreg[cmd.reg_select[2:0]] <= cmd.reg_value;
                                else if (cmd.reg_select < SEL_PC)
                                    areg[cmd.reg_select[2:0]] <= cmd.reg_value;
                                else if (cmd.reg_select == SEL_PC)
                                    pc_reg <= cmd.reg_value;
                                else if (cmd.reg_select == SEL_SR)
                                    sr_reg <= cmd.reg_value[15:0];
                                state_reg <= S_OUT;
                            end
                            KIND_REG_RD:
                            begin
                                if (cmd.reg_select < 5'd8)
                                    res_reg.read_value <= dreg[cmd.reg_select[2:0]];
                                else if (cmd.reg_select < SEL_PC)
                                    res_reg.read_value <= areg[cmd.reg_select[2:0]];
                                else if (cmd.reg_select == SEL_PC)
                                    res_reg.read_value <= pc_reg;
                                else if (cmd.reg_select == SEL_SR)
                                    res_reg.read_value <= {16'd0, sr_reg};
                                state_reg <= S_OUT;
                            end
                            default: state_reg <= S_OUT;
                        endcase
                    end
                end
                S_MEMRD:
                begin
                    res_reg.read_value <= cur_reg.mem_ok ? {24'd0, mrd_reg} : 32'd0;
                    state_reg <= S_OUT;
                end
                S_CHECK:
                begin
                    if (mode_reg == M_FETCH && cnt_reg >= cur_reg.step_limit)
                    begin
                        res_reg.status <= ST_LIMIT;
                        state_reg <= S_FINISH;
                    end
                    else if (!in_rng)
                    begin
                        res_reg.status <= ST_RANGE;
                        res_reg.fault_address <= ipc_reg;
                        res_reg.fault_opcode <= (mode_reg == M_FETCH) ? 16'd0 : op_reg;
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        bi_reg <= '0;
                        state_reg <= (mode_reg == M_STORE) ? S_WRITE : S_FETCH;
                    end
                end
                S_FETCH:
                begin
                    state_reg <= S_DATA;
                end
                S_DATA:
                begin
                    word_reg <= {word_reg[23:0], mrd_reg};
                    if (bi_reg == ((mode_reg == M_FETCH) ? 2'd1 : 2'd3))
                    begin
                        state_reg <= (mode_reg == M_FETCH) ? S_EXEC : S_EXTCHK;
                    end
                    else
                    begin
                        bi_reg <= bi_reg + 1'b1;
                        state_reg <= S_FETCH;
                    end
                end
                S_EXEC:
                begin
                    op_reg <= word_reg[15:0];
                    pc_reg <= ipc_reg + 32'd2;
                    state_reg <= S_EXTRD;
                end
                S_EXTRD:
                begin
                    if ((op_reg & MASK_MOVEQ) == CODE_MOVEQ)
                    begin
                        dreg[op_reg[11:9]] <= sext;
                        sr_reg[3:0] <= {sext[31], sext == 32'd0, 2'b00};
                        cnt_reg <= cnt_reg + 32'd1;
                        ipc_reg <= pc_reg;
                        ptr_reg <= pc_reg;
                        state_reg <= S_CHECK;
                    end
                    else if ((op_reg & MASK_QUICK) == CODE_QUICK && op_reg[5:3] == 3'd0)
                    begin
                        if (op_reg[8])
                        begin
                            dreg[op_reg[2:0]] <= dif;
                            sr_reg[4:0] <= {dst < qv, dif[31], dif == 32'd0,
                                (dst[31] ^ qv[31]) & (dst[31] ^ dif[31]), dst < qv};
                        end
                        else
                        begin
                            dreg[op_reg[2:0]] <= sum;
                            sr_reg[4:0] <= {sum < dst, sum[31], sum == 32'd0,
                                ~(dst[31] ^ qv[31]) & (dst[31] ^ sum[31]), sum < dst};
                        end
                        cnt_reg <= cnt_reg + 32'd1;
                        ipc_reg <= pc_reg;
                        ptr_reg <= pc_reg;
                        state_reg <= S_CHECK;
                    end
                    else if ((op_reg & MASK_STORE) == CODE_STORE
                        || (op_reg & MASK_LOAD) == CODE_LOAD)
                    begin
                        mode_reg <= M_EXT;
                        ptr_reg <= pc_reg;
                        state_reg <= S_CHECK;
                    end
                    else if (op_reg == CODE_RTS)
                    begin
                        mode_reg <= M_POP;
                        ptr_reg <= areg[7];
                        state_reg <= S_CHECK;
                    end
                    else
                    begin
                        pc_reg <= ipc_reg;
                        res_reg.status <= ST_ILLEGAL;
                        res_reg.fault_address <= ipc_reg;
                        res_reg.fault_opcode <= op_reg;
                        state_reg <= S_FINISH;
                    end
                end
                S_EXTCHK:
                begin
                    priority case (mode_reg)
                        M_EXT:
                        begin
                            pc_reg <= pc_reg + 32'd4;
                            addr_reg <= word_reg;
                            ptr_reg <= word_reg;
                            if ((op_reg & MASK_STORE) == CODE_STORE)
                            begin
                                mode_reg <= M_STORE;
                                word_reg <= dreg[op_reg[2:0]];
                            end
                            else
                            begin
                                mode_reg <= M_LOAD;
                            end
                            state_reg <= S_CHECK;
                        end
                        M_LOAD:
                        begin
                            dreg[op_reg[11:9]] <= word_reg;
                            sr_reg[3:0] <= {word_reg[31], word_reg == 32'd0, 2'b00};
                            cnt_reg <= cnt_reg + 32'd1;
                            mode_reg <= M_FETCH;
                            ipc_reg <= pc_reg;
                            ptr_reg <= pc_reg;
                            state_reg <= S_CHECK;
                        end
                        default:
                        begin
                            areg[7] <= areg[7] + 32'd4;
                            pc_reg <= word_reg;
                            cnt_reg <= cnt_reg + 32'd1;
                            res_reg.status <= ST_RTS;
                            state_reg <= S_FINISH;
                        end
                    endcase
                end
                S_WRITE:
                begin
                    word_reg <= {word_reg[23:0], 8'd0};
                    bi_reg <= bi_reg + 1'b1;
                    if (bi_reg == 2'd3)
                    begin
                        cnt_reg <= cnt_reg + 32'd1;
                        mode_reg <= M_FETCH;
                        ipc_reg <= pc_reg;
                        ptr_reg <= pc_reg;
                        state_reg <= S_CHECK;
                    end
                end
                S_FINISH:
                begin
                    res_reg.executed_count <= cnt_reg;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    logic unused;
    assign unused = ^addr_reg;
endmodule

// ----- hw/rtl/m68k_subset_interpreter_top.sv -----
// Top level of the 68000 subset interpreter.
//  channel   | dir | handshake              | payload
//  s_axis    | in  | s_axis_tvalid/tready   | request fields
//  m_axis    | out | m_axis_tvalid/tready   | result fields
//  cfg       | in  | cfg_valid/cfg_ready    | mem_size
// A request is held in the front queue until the back takes it; register and memory
// write results are registered in the back, and memory read results pass mrd_reg first.
// A run checks and fetches each opcode a byte at a time, reads long words (extension,
// load, pop) and writes long stores a byte at a time over the one byte memory port, then finishes.
// After reset a pass clears the memory before requests are taken.
// A two-entry queue lets the front accept while the back is busy or stalled.
module m68k_subset_interpreter_top (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // action[2:0], mem_address[14:3], mem_byte[22:15], reg_select[27:23],
    // reg_value[59:28], step_limit[91:60]
    input  logic [95:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // status[2:0], fault_address[34:3], fault_opcode[50:35],
    // executed_count[82:51], read_value[114:83]
    output logic [119:0] m_axis_tdata,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [12:0] cfg_data
);
    import m68k_pkg::*;

    logic [12:0] size_reg;
    logic cmd_valid, cmd_ready;
    cmd_t cmd;
    res_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= 13'd4096;
        end
        else if (cfg_valid)
        begin
            size_reg <= cfg_data;
        end
    end

    m68k_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .action(s_axis_tdata[2:0]), .mem_address(s_axis_tdata[14:3]),
        .mem_byte(s_axis_tdata[22:15]), .reg_select(s_axis_tdata[27:23]),
        .reg_value(s_axis_tdata[59:28]), .step_limit(s_axis_tdata[91:60]),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    m68k_back u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .mem_size(size_reg),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
    );

    assign m_axis_tdata = {5'd0, res.read_value, res.executed_count, res.fault_opcode,
        res.fault_address, res.status};

    logic unused;
    assign unused = ^s_axis_tdata[95:92];

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= ST_ILLEGAL)
        else $error("bad status");
    a_fault: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] != ST_RANGE && m_axis_tdata[2:0] != ST_ILLEGAL
        |-> m_axis_tdata[34:3] == 32'd0)
        else $error("fault address without fault");
endmodule
